// ===== rtl/fpfir_pkg.sv =====
// ----------------------------------------------------------------------------
// fpfir_pkg
// Shared widths, operation codes, register indexes and the control bundle
// that the top level broadcasts to every tap cell.
// ----------------------------------------------------------------------------
package fpfir_pkg;

    localparam int MAX_TAPS   = 32;
    localparam int DATA_W     = 16;
    localparam int ACC_W      = 32;
    localparam int COUNT_W    = 6;
    localparam int FRAC_W     = 5;
    localparam int OP_W       = 2;
    localparam int INDEX_W    = 5;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_ADDR_W = 1;

    // stages of start delay before the first cell consumes a sample's product
    localparam int START_DEPTH = 3;

    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_TAP_COUNT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAC_BITS = 1'b1;

    typedef struct packed {
        logic                     shift;
        logic                     clear;
        logic signed [DATA_W-1:0] tap_value;
        logic [FRAC_W-1:0]        frac_bits;
    } cell_ctrl_t;

endpackage

// ===== rtl/fpfir_cell.sv =====
// ----------------------------------------------------------------------------
// fpfir_cell
// One tap: a history sample and a coefficient, a registered product scaled
// toward zero, and a partial-sum stage that passes the sum to the next tap.
// ----------------------------------------------------------------------------
module fpfir_cell
    import fpfir_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctrl_t               ctrl,
    input  logic                     coef_we,
    input  logic                     active,
    input  logic signed [DATA_W-1:0] sample_in,
    output logic signed [DATA_W-1:0] sample_out,
    input  logic                     sum_valid_in,
    input  logic [ACC_W-1:0]         sum_in,
    output logic                     sum_valid_out,
    output logic [ACC_W-1:0]         sum_out
);

    logic signed [DATA_W-1:0] history_reg, history_next;
    logic signed [DATA_W-1:0] coef_reg, coef_next;
    logic signed [ACC_W-1:0]  prod_reg, prod_next;
    logic [ACC_W-1:0]         scaled_reg, scaled_next;
    logic                     sum_valid_reg;
    logic [ACC_W-1:0]         sum_reg, sum_next;

    logic [ACC_W:0]           round_mask;
    logic [ACC_W:0]           biased;
    logic signed [ACC_W:0]    shifted;

    always_comb
    begin
        history_next = history_reg;
        if (ctrl.clear)
        begin
            history_next = '0;
        end
        else if (ctrl.shift)
        begin
            history_next = sample_in;
        end
    end

    assign coef_next = coef_we ? ctrl.tap_value : coef_reg;
    assign prod_next = ACC_W'(history_reg) * ACC_W'(coef_reg);

    // add 2^s-1 to negative products so the arithmetic shift rounds toward zero
    always_comb
    begin
        round_mask  = ((ACC_W+1)'(1) << ctrl.frac_bits) - (ACC_W+1)'(1);
        biased      = {prod_reg[ACC_W-1], prod_reg}
                    + (prod_reg[ACC_W-1] ? round_mask : '0);
        shifted     = $signed(biased) >>> ctrl.frac_bits;
        scaled_next = shifted[ACC_W-1:0];
    end

    assign sum_next = sum_in + (active ? scaled_reg : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg   <= '0;
            coef_reg      <= '0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            history_reg   <= history_next;
            coef_reg      <= coef_next;
            sum_valid_reg <= sum_valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        scaled_reg <= scaled_next;
        if (sum_valid_in)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sample_out    = history_reg;
    assign sum_valid_out = sum_valid_reg;
    assign sum_out       = sum_reg;

endmodule

// ===== rtl/fixed_point_fir_convolution.sv =====
// ----------------------------------------------------------------------------
// fixed_point_fir_convolution
// Direct-form FIR filter built as a row of tap cells with a rippling sum.
// ----------------------------------------------------------------------------
// A sample transaction shifts the history through all MAX_TAPS cells at once;
// each cell then forms its scaled product and the partial sum walks down the
// row one cell per cycle. Tap writes and history clears produce no result.
// A finished result waits in a holding stage until the output register can
// take it. No new transaction is taken before it has moved, but after that
// the block takes input again even while the output register still waits
// on a stall. The user must see that configuration is written only while
// idle; the block itself does not enforce it.
module fixed_point_fir_convolution
    import fpfir_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [CFG_ADDR_W-1:0]    wr_index,
    input  logic [CFG_DATA_W-1:0]    wr_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          operation,
    input  logic signed [DATA_W-1:0] sample_value,
    input  logic [INDEX_W-1:0]       tap_index,
    input  logic signed [DATA_W-1:0] tap_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [ACC_W-1:0]  filtered_value
);

    logic [COUNT_W-1:0]     tap_count_reg, tap_count_next;
    logic [FRAC_W-1:0]      frac_bits_reg, frac_bits_next;
    logic                   busy_reg, busy_next;
    logic [START_DEPTH-1:0] start_reg, start_next;
    logic                   pending_valid_reg, pending_valid_next;
    logic [ACC_W-1:0]       pending_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [ACC_W-1:0]       out_data_reg;

    logic                   in_fire;
    logic                   sample_fire;
    logic                   move_out;
    cell_ctrl_t             ctrl;

    logic signed [DATA_W-1:0] sample_chain [MAX_TAPS+1];
    logic [ACC_W-1:0]         sum_chain    [MAX_TAPS+1];
    logic [MAX_TAPS:0]        valid_chain;

    assign in_stall    = busy_reg;
    assign in_fire     = in_valid && !in_stall;
    assign sample_fire = in_fire && (operation == OP_SAMPLE);
    assign move_out    = pending_valid_reg && (!out_valid_reg || !out_stall);

    assign ctrl.shift     = sample_fire;
    assign ctrl.clear     = in_fire && (operation == OP_CLEAR);
    assign ctrl.tap_value = tap_value;
    assign ctrl.frac_bits = frac_bits_reg;

    assign sample_chain[0] = sample_value;
    assign sum_chain[0]    = '0;
    assign valid_chain[0]  = start_reg[START_DEPTH-1];

    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_tap
        logic coef_we;
        logic active;

        assign coef_we = in_fire && (operation == OP_WRITE)
                       && (32'(tap_index) == k);
        assign active  = (k < 32'(tap_count_reg));

        fpfir_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .coef_we       (coef_we),
            .active        (active),
            .sample_in     (sample_chain[k]),
            .sample_out    (sample_chain[k+1]),
            .sum_valid_in  (valid_chain[k]),
            .sum_in        (sum_chain[k]),
            .sum_valid_out (valid_chain[k+1]),
            .sum_out       (sum_chain[k+1])
        );
    end

    always_comb
    begin
        tap_count_next = tap_count_reg;
        frac_bits_next = frac_bits_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_TAP_COUNT: tap_count_next = wr_data;
                REG_FRAC_BITS: frac_bits_next = wr_data[FRAC_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        start_next = {start_reg[START_DEPTH-2:0], sample_fire};

        busy_next = busy_reg;
        if (sample_fire)
        begin
            busy_next = 1'b1;
        end
        else if (move_out)
        begin
            busy_next = 1'b0;
        end

        pending_valid_next = pending_valid_reg;
        if (valid_chain[MAX_TAPS])
        begin
            pending_valid_next = 1'b1;
        end
        else if (move_out)
        begin
            pending_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (move_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg     <= COUNT_W'(1);
            frac_bits_reg     <= '0;
            busy_reg          <= 1'b0;
            start_reg         <= '0;
            pending_valid_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            tap_count_reg     <= tap_count_next;
            frac_bits_reg     <= frac_bits_next;
            busy_reg          <= busy_next;
            start_reg         <= start_next;
            pending_valid_reg <= pending_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_chain[MAX_TAPS])
        begin
            pending_reg <= sum_chain[MAX_TAPS];
        end
        if (move_out)
        begin
            out_data_reg <= pending_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = $signed(out_data_reg);

    // only one sum may travel the row at a time
    a_single_sum: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_chain) <= 1)
        else $error("more than one partial sum in the tap row");

    // the holding stage is always free when the row delivers
    a_pending_free: assert property (@(posedge clk) disable iff (!rst_n)
        valid_chain[MAX_TAPS] |-> !pending_valid_reg)
        else $error("tap row result overran the holding stage");

    // idle means nothing in flight
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (valid_chain == '0) && (start_reg == '0) && !pending_valid_reg)
        else $error("work in flight while input is open");

    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        sample_fire |=> busy_reg && start_reg[0])
        else $error("sample transaction did not start the tap row");

endmodule
